@@ hdl/lzbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzbd_pkg
// Shared types and constants of the LZ4 block decompressor.
// ----------------------------------------------------------------------------
package lzbd_pkg;

  typedef enum logic [1:0] {
    OP_BYTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_FINISH  = 2'd1,
    ST_ERROR   = 2'd2,
    ST_REFUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_TOKEN   = 3'd0,
    PH_LITEXT  = 3'd1,
    PH_LIT     = 3'd2,
    PH_LASTLIT = 3'd3,
    PH_OFFLO   = 3'd4,
    PH_OFFHI   = 3'd5,
    PH_MLEXT   = 3'd6,
    PH_DONE    = 3'd7
  } phase_t;

  localparam logic [2:0] CFG_END_ON_INPUT = 3'd0;
  localparam logic [2:0] CFG_PARTIAL      = 3'd1;
  localparam logic [2:0] CFG_TARGET       = 3'd2;
  localparam logic [2:0] CFG_CAPACITY     = 3'd3;
  localparam logic [2:0] CFG_INPUT_SIZE   = 3'd4;

  localparam int END_GUARD = 12;
  localparam int TAIL_LITS = 5;
  localparam int COPY_SLACK = 8;
  localparam int MIN_MATCH = 4;
  localparam logic [3:0] NIBBLE = 4'hF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               has_byte;
    logic               match_pending;
    logic [1:0]         status;
    logic signed [31:0] result_value;
  } out_item_t;

endpackage
`default_nettype wire

@@ hdl/lz_block_decompressor_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lz_block_decompressor_unit
// LZ4 block decoder: parses one compressed byte or drains one match byte per
// item, keeping the output history in a synchronous RAM.
// ----------------------------------------------------------------------------
// A result shows on out_data in the cycle after its item is accepted.
// Throughput: one item per cycle, literals and match ticks alike, while the output
//   is not stalled; the single history RAM port pair (read at accept, write as
//   the result leaves) and a forward path for the output register's byte set this rate.
// Reset (rst_n low, synchronous): clears parser state, counters and the
//   output valid flag; config returns to end_on_input=1, all else 0. History
//   RAM is not cleared: reads never reach unwritten entries.
module lz_block_decompressor_unit #(
  parameter int HISTORY_BYTES = 65536
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire lzbd_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output lzbd_pkg::out_item_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [30:0]          cfg_data
);
  import lzbd_pkg::*;

  localparam int HA = $clog2(HISTORY_BYTES);

  // Output stage contents; the byte of a tick comes from RAM read data or the forwarded byte.
  typedef struct packed {
    logic          wr;
    logic          tick;
    logic [HA-1:0] addr;
    logic [7:0]    lit_byte;
    logic          fwd;
    logic [7:0]    fwd_byte;
    logic          pending;
    logic [1:0]    status;
    logic [31:0]   value;
  } stage_t;

  typedef struct packed {
    phase_t ph;
    logic   fail;
    logic   fin;
  } dec_t;

  // Configuration
  logic        eoi_r, partial_r;
  logic [30:0] target_r, cap_r, isize_r;

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic [31:0] lit_r, lit_nxt, ml_r, ml_nxt, br_r, br_nxt, bw_r, bw_nxt;
  logic [15:0] dist_r, dist_nxt;
  logic [3:0]  nib_r, nib_nxt;
  logic [1:0]  dst_r, dst_nxt;
  logic [31:0] dval_r, dval_nxt;

  logic   s1_valid_r, s1_valid_nxt;
  stage_t s1_r, s1_nxt;

  logic          in_acc, out_acc;
  logic          rd_en;
  logic [HA-1:0] raddr;
  logic [7:0]    rdata, s1_byte;
  logic          pending;
  logic          refused;
  logic          emit_lit, emit_tick;
  dec_t          dec;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // Literal-run decision after the literal length is known.
  function automatic dec_t lit_decide(input logic [31:0] len, input logic [31:0] rd,
                                      input logic [31:0] bw, input logic eoi,
                                      input logic part, input logic [30:0] tgt,
                                      input logic [30:0] cap, input logic [30:0] isz);
    dec_t d;
    logic signed [34:0] cpy, lim, rdl, oend, iend;
    logic last, err;
    cpy  = $signed({3'b0, bw}) + $signed({3'b0, len});
    rdl  = $signed({3'b0, rd}) + $signed({3'b0, len});
    oend = $signed({4'b0, cap});
    iend = $signed({4'b0, isz});
    lim  = oend - 35'(END_GUARD);
    d    = '{ph: PH_DONE, fail: 1'b0, fin: 1'b0};
    if (eoi) begin
      if (part && ($signed({4'b0, tgt}) < lim)) begin
        lim = $signed({4'b0, tgt});
      end
      last = (cpy > lim) || (rdl > iend - 35'(2 + 1 + TAIL_LITS));
    end else begin
      last = cpy > oend - 35'(COPY_SLACK);
    end
    if (part) begin
      err = (cpy > oend) || (eoi && (rdl > iend));
    end else if (eoi) begin
      err = (rdl != iend) || (cpy > oend);
    end else begin
      err = cpy != oend;
    end
    if (!last) begin
      d.ph = (len != 32'd0) ? PH_LIT : PH_OFFLO;
    end else if (err) begin
      d.fail = 1'b1;
    end else if (len == 32'd0) begin
      d.fin = 1'b1;
    end else begin
      d.ph = PH_LASTLIT;
    end
    return d;
  endfunction

  assign in_stall  = s1_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_acc   = s1_valid_r & ~out_stall;
  assign out_valid = s1_valid_r;
  assign pending   = (phase_r == PH_TOKEN) && (ml_r != 32'd0);
  assign raddr     = HA'(bw_r[HA-1:0] - dist_r[HA-1:0]);

  // Byte carried by the output stage.
  always_comb begin
    if (!s1_r.tick) begin
      s1_byte = s1_r.lit_byte;
    end else if (s1_r.fwd) begin
      s1_byte = s1_r.fwd_byte;
    end else begin
      s1_byte = rdata;
    end
  end

  // Parser: walk the block grammar for one accepted item.
  always_comb begin
    logic        ok, more_ml, mfail;
    logic [31:0] bw_tmp;
    logic [34:0] mend;
    phase_nxt = phase_r;
    lit_nxt   = lit_r;
    ml_nxt    = ml_r;
    br_nxt    = br_r;
    bw_nxt    = bw_r;
    dist_nxt  = dist_r;
    nib_nxt   = nib_r;
    dst_nxt   = dst_r;
    dval_nxt  = dval_r;
    refused   = 1'b0;
    emit_lit  = 1'b0;
    emit_tick = 1'b0;
    rd_en     = 1'b0;
    dec       = '{ph: PH_DONE, fail: 1'b0, fin: 1'b0};
    ok        = 1'b0;
    more_ml   = 1'b0;
    mfail     = 1'b0;
    bw_tmp    = 32'd0;
    mend      = 35'd0;
    if (in_acc) begin
      case (in_data.op)
        OP_START: begin
          phase_nxt = PH_TOKEN;
          lit_nxt   = 32'd0;
          ml_nxt    = 32'd0;
          br_nxt    = 32'd0;
          bw_nxt    = 32'd0;
          dist_nxt  = 16'd0;
          nib_nxt   = 4'd0;
          dst_nxt   = ST_RUN;
          dval_nxt  = 32'd0;
        end
        OP_TICK: begin
          if (pending) begin
            rd_en     = 1'b1;
            emit_tick = 1'b1;
            bw_nxt    = sat_add(bw_r, 32'd1);
            ml_nxt    = ml_r - 32'd1;
          end
        end
        OP_BYTE: begin
          if (pending) begin
            refused = 1'b1;
          end else if (phase_r != PH_DONE) begin
            if (phase_r == PH_TOKEN && br_r == 32'd0 && cap_r == 31'd0) begin
              // Zero-capacity block: the first byte settles the outcome.
              br_nxt    = sat_add(br_r, 32'd1);
              phase_nxt = PH_DONE;
              if (eoi_r) begin
                ok       = (isize_r == 31'd1) && (in_data.in_byte == 8'd0);
                dst_nxt  = ok ? ST_FINISH : ST_ERROR;
                dval_nxt = ok ? 32'd0 : 32'hFFFF_FFFF;
              end else begin
                ok       = in_data.in_byte == 8'd0;
                dst_nxt  = ok ? ST_FINISH : ST_ERROR;
                dval_nxt = ok ? 32'd1 : 32'hFFFF_FFFF;
              end
            end else if (eoi_r && (br_r >= {1'b0, isize_r})) begin
              phase_nxt = PH_DONE;
              dst_nxt   = ST_ERROR;
              dval_nxt  = ~br_r;
            end else begin
              br_nxt  = sat_add(br_r, 32'd1);
              more_ml = !eoi_r ||
                        ($signed({3'b0, br_nxt}) < $signed({4'b0, isize_r}) - 35'sd6);
              case (phase_r)
                PH_TOKEN: begin
                  nib_nxt = in_data.in_byte[3:0];
                  lit_nxt = {28'd0, in_data.in_byte[7:4]};
                  if (in_data.in_byte[7:4] == NIBBLE &&
                      (!eoi_r || br_nxt < {1'b0, isize_r})) begin
                    dec.ph = PH_LITEXT;
                  end else begin
                    dec = lit_decide(lit_nxt, br_nxt, bw_r, eoi_r, partial_r,
                                     target_r, cap_r, isize_r);
                  end
                end
                PH_LITEXT: begin
                  lit_nxt = sat_add(lit_r, {24'd0, in_data.in_byte});
                  if (!(in_data.in_byte == 8'hFF &&
                        (!eoi_r || br_nxt < {1'b0, isize_r}))) begin
                    dec = lit_decide(lit_nxt, br_nxt, bw_r, eoi_r, partial_r,
                                     target_r, cap_r, isize_r);
                  end else begin
                    dec.ph = PH_LITEXT;
                  end
                end
                PH_LIT, PH_LASTLIT: begin
                  emit_lit = 1'b1;
                  bw_nxt   = sat_add(bw_r, 32'd1);
                  lit_nxt  = lit_r - 32'd1;
                  dec.ph   = phase_r;
                  if (lit_nxt == 32'd0) begin
                    if (phase_r == PH_LIT) dec.ph = PH_OFFLO;
                    else dec.fin = 1'b1;
                  end
                end
                PH_OFFLO: begin
                  dist_nxt = {8'd0, in_data.in_byte};
                  dec.ph   = PH_OFFHI;
                end
                PH_OFFHI: begin
                  dist_nxt = {in_data.in_byte, dist_r[7:0]};
                  if (dist_nxt == 16'd0 || {16'd0, dist_nxt} > bw_r) begin
                    dec.fail = 1'b1;
                  end else begin
                    ml_nxt = {28'd0, nib_r};
                    if (nib_r == NIBBLE && more_ml) begin
                      dec.ph = PH_MLEXT;
                    end else begin
                      mfail = 1'b1;
                    end
                  end
                end
                default: begin
                  ml_nxt = sat_add(ml_r, {24'd0, in_data.in_byte});
                  if (!(in_data.in_byte == 8'hFF && more_ml)) begin
                    mfail = 1'b1;
                  end else begin
                    dec.ph = PH_MLEXT;
                  end
                end
              endcase
              // Match end check; mfail marks that a decision is due.
              if (mfail) begin
                mend = {3'b0, bw_r} + {3'b0, ml_nxt} + 35'(MIN_MATCH);
                if ($signed(mend) > $signed({4'b0, cap_r}) - 35'(TAIL_LITS)) begin
                  dec.fail = 1'b1;
                end else begin
                  ml_nxt = ml_nxt + 32'(MIN_MATCH);
                  dec.ph = PH_TOKEN;
                end
              end
              bw_tmp = bw_nxt;
              if (dec.fail) begin
                phase_nxt = PH_DONE;
                dst_nxt   = ST_ERROR;
                dval_nxt  = ~br_nxt;
              end else if (dec.fin) begin
                phase_nxt = PH_DONE;
                dst_nxt   = ST_FINISH;
                dval_nxt  = eoi_r ? bw_tmp : br_nxt;
              end else begin
                phase_nxt = dec.ph;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Load the output stage; drop it once taken.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_nxt       = s1_r;
    if (out_acc) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc && (in_data.op == OP_BYTE || in_data.op == OP_TICK)) begin
      s1_valid_nxt    = 1'b1;
      s1_nxt.wr       = emit_lit | emit_tick;
      s1_nxt.tick     = emit_tick;
      s1_nxt.addr     = bw_r[HA-1:0];
      s1_nxt.lit_byte = emit_lit ? in_data.in_byte : 8'd0;
      // Forward the byte that leaves the output stage this cycle.
      s1_nxt.fwd      = s1_valid_r & s1_r.wr & (s1_r.addr == raddr);
      s1_nxt.fwd_byte = s1_byte;
      s1_nxt.pending  = (phase_nxt == PH_TOKEN) && (ml_nxt != 32'd0);
      if (refused) begin
        s1_nxt.status = ST_REFUSED;
        s1_nxt.value  = 32'd0;
      end else if (phase_nxt == PH_DONE) begin
        s1_nxt.status = dst_nxt;
        s1_nxt.value  = dval_nxt;
      end else begin
        s1_nxt.status = ST_RUN;
        s1_nxt.value  = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eoi_r      <= 1'b1;
      partial_r  <= 1'b0;
      target_r   <= 31'd0;
      cap_r      <= 31'd0;
      isize_r    <= 31'd0;
      phase_r    <= PH_TOKEN;
      lit_r      <= 32'd0;
      ml_r       <= 32'd0;
      br_r       <= 32'd0;
      bw_r       <= 32'd0;
      dist_r     <= 16'd0;
      nib_r      <= 4'd0;
      dst_r      <= ST_RUN;
      dval_r     <= 32'd0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_END_ON_INPUT: eoi_r     <= cfg_data[0];
          CFG_PARTIAL:      partial_r <= cfg_data[0];
          CFG_TARGET:       target_r  <= cfg_data;
          CFG_CAPACITY:     cap_r     <= cfg_data;
          CFG_INPUT_SIZE:   isize_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      phase_r    <= phase_nxt;
      lit_r      <= lit_nxt;
      ml_r       <= ml_nxt;
      br_r       <= br_nxt;
      bw_r       <= bw_nxt;
      dist_r     <= dist_nxt;
      nib_r      <= nib_nxt;
      dst_r      <= dst_nxt;
      dval_r     <= dval_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // History write happens as the item carrying the byte leaves.
  lzbd_hist_ram #(
    .DEPTH(HISTORY_BYTES)
  ) u_hist (
    .clk   (clk),
    .we    (out_acc & s1_r.wr),
    .waddr (s1_r.addr),
    .wdata (s1_byte),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    out_data.out_byte      = s1_r.wr ? s1_byte : 8'd0;
    out_data.has_byte      = s1_r.wr;
    out_data.match_pending = s1_r.pending;
    out_data.status        = s1_r.status;
    out_data.result_value  = s1_r.value;
  end
endmodule
`default_nettype wire

@@ hdl/lzbd_hist_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzbd_hist_ram
// History buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzbd_hist_ram #(
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [7:0]               wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [7:0]               rdata
);
  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

@@ hdl/lzbd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lzbd_checker
// Port-level checks of the decompressor, bound to the top level.
// ----------------------------------------------------------------------------
module lzbd_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire lzbd_pkg::out_item_t out_data
);
  import lzbd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |-> out_data.out_byte == 8'd0)
    else $error("byte shown without has_byte");

  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_REFUSED |->
      !out_data.has_byte && out_data.match_pending && out_data.result_value == 0)
    else $error("refused byte result malformed");

  a_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_RUN |-> out_data.result_value == 0)
    else $error("running result carries a value");
endmodule

bind lz_block_decompressor_unit lzbd_checker u_lzbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
